>>> sv/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants for the preemptive priority scheduler: field
// widths, request and status codes, queue entry and result records.
// ----------------------------------------------------------------------------
package pps_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int BURST_BITS  = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Transaction field widths
  localparam int ID_W    = 4;
  localparam int PRIO_W  = 8;
  localparam int BURST_W = 16;
  localparam int COUNT_W = 5;

  // Request codes
  localparam logic REQ_ARRIVAL = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_ACCEPT = 2'd0,
    ST_REJECT = 2'd1,
    ST_RAN    = 2'd2,
    ST_IDLE   = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_INS,
    S_CMP,
    S_RESP
  } state_t;

  // One ready queue entry
  typedef struct packed {
    logic [ID_W-1:0]       id;
    logic [PRIO_W-1:0]     prio;
    logic [BURST_BITS-1:0] rem;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Result record held until the output register is free
  typedef struct packed {
    status_t            status;
    logic [ID_W-1:0]    run_id;
    logic               done;
    logic [BURST_W-1:0] remaining;
  } result_t;

endpackage

>>> sv/pps_in_if.sv
// ----------------------------------------------------------------------------
// pps_in_if
// Request channel: task arrivals and scheduler ticks with valid/ready.
// ----------------------------------------------------------------------------
interface pps_in_if ();
  import pps_pkg::*;

  logic               valid;
  logic               ready;
  logic               req_type;
  logic [ID_W-1:0]    task_id;
  logic [PRIO_W-1:0]  task_priority;
  logic [BURST_W-1:0] burst_length;

  modport source (
    output valid, req_type, task_id, task_priority, burst_length,
    input  ready
  );

  modport sink (
    input  valid, req_type, task_id, task_priority, burst_length,
    output ready
  );
endinterface

>>> sv/pps_out_if.sv
// ----------------------------------------------------------------------------
// pps_out_if
// Result channel: one status transaction per request, with valid/ready.
// ----------------------------------------------------------------------------
interface pps_out_if ();
  import pps_pkg::*;

  logic               valid;
  logic               ready;
  status_t            status;
  logic [ID_W-1:0]    run_task_id;
  logic               task_done;
  logic [BURST_W-1:0] remaining_after;
  logic [COUNT_W-1:0] ready_count;

  modport source (
    output valid, status, run_task_id, task_done, remaining_after, ready_count,
    input  ready
  );

  modport sink (
    input  valid, status, run_task_id, task_done, remaining_after, ready_count,
    output ready
  );
endinterface

>>> sv/preemptive_priority_scheduler.sv
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Sorted ready queue with priority/remaining-time ordering; arrivals insert,
// ticks run the head for one tick and re-insert it if time is left.
// ----------------------------------------------------------------------------
// The queue lives in a circular buffer in one RAM; removing the head only
// moves the head pointer, and an insert walks from the tail toward the head,
// shifting one entry up per cycle through the single read port until it
// finds its slot; it passes at most QUEUE_DEPTH - 1 entries. A result that
// finds the output register still full waits in S_RESP until it is free.
// The input is not ready while a request is in progress; a new request is
// accepted while the previous result still waits in the output register.
// No clearing pass is needed after reset: only entries below the fill count
// are ever used.
module preemptive_priority_scheduler (
  input  logic  clk,
  input  logic  rst_n,
  pps_in_if.sink    in_ch,
  pps_out_if.source out_ch
);
  import pps_pkg::*;

  // Map a queue position to a RAM address relative to the head
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                            input logic [IDX_W-1:0] ofs);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, ofs};
    if (sum >= (IDX_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (IDX_W+1)'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   size_r, size_nxt;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [IDX_W-1:0]   pos_r, pos_nxt;
  entry_t             item_r, item_nxt;
  result_t            res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  result_t            out_res_r, out_res_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  entry_t             ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  entry_t             ram_rdata;

  logic                  acc;
  logic                  is_tick;
  logic [BURST_BITS-1:0] burst;
  logic                  reject;
  logic [BURST_BITS-1:0] head_dec;
  logic                  stop;
  logic [IDX_W-1:0]      pos_dec;
  logic                  out_free;

  // Queue storage
  pps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared conditions
  assign acc      = in_ch.valid && in_ch.ready;
  assign is_tick  = (in_ch.req_type == REQ_TICK);
  assign burst    = in_ch.burst_length[BURST_BITS-1:0];
  assign reject   = (burst == '0) || (size_r >= CNT_W'(QUEUE_DEPTH));
  assign head_dec = ram_rdata.rem - 1'b1;
  assign pos_dec  = pos_r - 1'b1;
  assign out_free = !out_valid_r || out_ch.ready;
  // Insert slot found: the entry ahead outranks or ties with the new one
  assign stop     = (ram_rdata.prio > item_r.prio) ||
                    ((ram_rdata.prio == item_r.prio) && (ram_rdata.rem <= item_r.rem));

  assign in_ch.ready = (state_r == S_IDLE);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (is_tick) begin
            state_nxt = (size_r == '0) ? S_RESP : S_HEAD;
          end else begin
            state_nxt = reject ? S_RESP : S_INS;
          end
        end
      end
      S_HEAD: begin
        state_nxt = (head_dec == '0) ? S_RESP : S_INS;
      end
      S_INS: begin
        state_nxt = (pos_r == '0) ? S_RESP : S_CMP;
      end
      S_CMP: begin
        if (stop) begin
          state_nxt = S_RESP;
        end else if (pos_dec == '0) begin
          state_nxt = S_INS;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    size_nxt      = size_r;
    head_nxt      = head_r;
    pos_nxt       = pos_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_res_nxt   = out_res_r;
    out_count_nxt = out_count_r;
    ram_we        = 1'b0;
    ram_waddr     = phys(head_r, pos_r);
    ram_wdata     = item_r;
    ram_raddr     = phys(head_r, pos_dec);

    unique case (state_r)
      S_IDLE: begin
        ram_raddr = head_r;
        if (acc) begin
          res_nxt = '{status: ST_ACCEPT, run_id: '0, done: 1'b0, remaining: '0};
          if (is_tick) begin
            if (size_r == '0) begin
              res_nxt.status = ST_IDLE;
            end
          end else if (reject) begin
            res_nxt.status = ST_REJECT;
          end else begin
            item_nxt = '{id: in_ch.task_id, prio: in_ch.task_priority, rem: burst};
            pos_nxt  = size_r[IDX_W-1:0];
          end
        end
      end
      // Pop the head, run one tick, queue it for re-insert at the tail if time is left
      S_HEAD: begin
        head_nxt = phys(head_r, IDX_W'(1));
        size_nxt = size_r - 1'b1;
        res_nxt  = '{status: ST_RAN, run_id: ram_rdata.id, done: (head_dec == '0),
                     remaining: BURST_W'(head_dec)};
        item_nxt = '{id: ram_rdata.id, prio: ram_rdata.prio, rem: head_dec};
        pos_nxt  = IDX_W'(size_r - 1'b1);
      end
      // Write at the head slot, or start the walk with a read of the entry ahead
      S_INS: begin
        if (pos_r == '0) begin
          ram_we   = 1'b1;
          size_nxt = size_r + 1'b1;
        end
      end
      // Compare with the entry ahead; drop the item in or shift that entry up
      S_CMP: begin
        ram_we = 1'b1;
        if (stop) begin
          size_nxt = size_r + 1'b1;
        end else begin
          ram_wdata = ram_rdata;
          pos_nxt   = pos_dec;
          ram_raddr = phys(head_r, pos_r - IDX_W'(2));
        end
      end
      // Hand the result to the output register once it is free
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          out_count_nxt = COUNT_W'(size_r);
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      size_r      <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    item_r      <= item_nxt;
    res_r       <= res_nxt;
    out_res_r   <= out_res_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_res_r.status;
  assign out_ch.run_task_id     = out_res_r.run_id;
  assign out_ch.task_done       = out_res_r.done;
  assign out_ch.remaining_after = out_res_r.remaining;
  assign out_ch.ready_count     = out_count_r;

`ifndef SYNTHESIS
  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    size_r <= CNT_W'(QUEUE_DEPTH))
    else $error("ready queue count exceeds depth");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_HEAD |=> size_r == CNT_W'($past(size_r) - 1'b1))
    else $error("head pop did not shrink the queue by one");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_RESP) |-> !ram_we)
    else $error("queue write outside an insert");

  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_RESP)
    else $error("result presented without a finished request");
`endif

endmodule

>>> sv/pps_ram.sv
// ----------------------------------------------------------------------------
// pps_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
